// ----- src/sfg_pkg.sv -----
package sfg_pkg;

	localparam int REG_IDX_W = 3;
	localparam int CFG_W     = 15;

	localparam logic [REG_IDX_W-1:0] REG_MODE  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_INV_X = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_INV_Y = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_SCL_S = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_SCL_T = 3'd4;

	localparam logic [1:0] MODE_PLANAR = 2'd1;
	localparam logic [1:0] MODE_SPHERE = 2'd2;

	localparam int CW       = 34;  // CORDIC x/y width
	localparam int AW       = 35;  // CORDIC angle width, Q30 radians
	localparam int QW       = 18;  // unscaled Q.12 coordinate width
	localparam int RW       = 57;  // isqrt radicand/root width
	localparam int SQ_STEPS = 29;  // one root bit per stage
	localparam int ATAN_LEN = 24;

	localparam logic signed [AW-1:0] PI_Q30      = 35'sd3373259426;
	localparam logic signed [31:0]   INV_2PI_Q32 = 32'sd683565276;
	localparam logic signed [31:0]   INV_PI_Q32  = 32'sd1367130551;
	localparam logic signed [QW-1:0] HALF_Q12    = 18'sd2048;
	localparam logic signed [QW-1:0] SEAM_Q12    = 18'sd3072;
	localparam logic signed [QW-1:0] ONE_Q12     = 18'sd4096;

	typedef struct packed {
		logic                 zr;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [AW-1:0] a;
	} cord_t;

	typedef struct packed {
		logic signed [15:0]   x;
		logic signed [15:0]   z;
		logic signed [15:0]   yc;
		logic [RW-1:0]        rem;
		logic [RW-1:0]        root;
		logic signed [31:0]   ps;
		logic signed [31:0]   pt;
		cord_t                cs;
		cord_t                ct;
		logic signed [49:0]   shi;
		logic signed [49:0]   slo;
		logic signed [49:0]   thi;
		logic signed [49:0]   tlo;
		logic signed [QW-1:0] s;
		logic signed [QW-1:0] t;
		logic signed [33:0]   ms;
		logic signed [33:0]   mt;
	} vtx_t;

	typedef struct packed {
		logic           sph;
		vtx_t [2:0]     v;
	} item_t;

	function automatic logic signed [AW-1:0] atan_q30(int i);
		case (i)
			0:  return 35'sd843314856;
			1:  return 35'sd497837829;
			2:  return 35'sd263043836;
			3:  return 35'sd133525158;
			4:  return 35'sd67021686;
			5:  return 35'sd33543515;
			6:  return 35'sd16775850;
			7:  return 35'sd8388437;
			8:  return 35'sd4194282;
			9:  return 35'sd2097149;
			10: return 35'sd1048575;
			11: return 35'sd524287;
			12: return 35'sd262143;
			13: return 35'sd131071;
			14: return 35'sd65535;
			15: return 35'sd32767;
			16: return 35'sd16383;
			17: return 35'sd8191;
			18: return 35'sd4095;
			19: return 35'sd2047;
			20: return 35'sd1023;
			21: return 35'sd511;
			22: return 35'sd255;
			23: return 35'sd127;
			default: return '0;
		endcase
	endfunction

endpackage

// ----- src/sfg_in_if.sv -----
interface sfg_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] v1_x;
	logic signed [15:0] v1_y;
	logic signed [15:0] v1_z;
	logic signed [15:0] v2_x;
	logic signed [15:0] v2_y;
	logic signed [15:0] v2_z;
	logic signed [15:0] v3_x;
	logic signed [15:0] v3_y;
	logic signed [15:0] v3_z;

	modport source(output valid, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, v3_x, v3_y, v3_z,
		input ready);
	modport sink(input valid, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, v3_x, v3_y, v3_z,
		output ready);
endinterface

// ----- src/sfg_out_if.sv -----
interface sfg_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] s_first;
	logic signed [15:0] t_first;
	logic signed [15:0] s_second;
	logic signed [15:0] t_second;
	logic signed [15:0] s_third;
	logic signed [15:0] t_third;

	modport source(output valid, s_first, t_first, s_second, t_second, s_third, t_third,
		input ready);
	modport sink(input valid, s_first, t_first, s_second, t_second, s_third, t_third,
		output ready);
endinterface

// ----- src/sphere_face_texcoord_gen.sv -----
// One face per cycle unless the output stalls; the 29-stage square root, the CORDIC stages
// and the split angle multiply are all fully pipelined.
// A stalled output freezes the whole pipeline; input ready is low only then.
// Reset clears all valid bits and loads the register defaults (planar mode, scales 1.0).
module sphere_face_texcoord_gen #(
	parameter int CORDIC_ITERATIONS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [sfg_pkg::REG_IDX_W-1:0]  cfg_idx,
	input  logic [sfg_pkg::CFG_W-1:0]      cfg_wdata,
	sfg_in_if.sink                         face,
	sfg_out_if.source                      tc
);
	import sfg_pkg::*;

	localparam int NI = CORDIC_ITERATIONS;

	logic [1:0]  mode_q;
	logic [14:0] inv_x_q, inv_y_q, scl_s_q, scl_t_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_PLANAR;
			inv_x_q <= 15'd4096;
			inv_y_q <= 15'd4096;
			scl_s_q <= 15'd4096;
			scl_t_q <= 15'd4096;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_MODE:  mode_q  <= cfg_wdata[1:0];
				REG_INV_X: inv_x_q <= cfg_wdata;
				REG_INV_Y: inv_y_q <= cfg_wdata;
				REG_SCL_S: scl_s_q <= cfg_wdata;
				REG_SCL_T: scl_t_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- functions
	function automatic vtx_t entry_f(logic signed [15:0] x, logic signed [15:0] y,
		logic signed [15:0] z, logic [14:0] ivx, logic [14:0] ivy);
		logic signed [15:0] yc;
		logic [31:0]        ysq;
		vtx_t               r;
		r  = '0;
		yc = (y > 16'sd16384) ? 16'sd16384 : ((y < -16'sd16384) ? -16'sd16384 : y);
		ysq = 32'(yc) * 32'(yc);
		// radicand = 2^56 - (yc*2^14)^2
		r.rem = (RW'(1) << 56) - (RW'(ysq) << 28);
		r.ps  = x * $signed({1'b0, ivx});
		r.pt  = y * $signed({1'b0, ivy});
		r.x   = x;
		r.z   = z;
		r.yc  = yc;
		return r;
	endfunction

	function automatic vtx_t sq_vtx(vtx_t v, int g);
		logic [RW-1:0] bitv;
		logic [RW:0]   tr;
		bitv = RW'(1) << (56 - 2 * g);
		tr   = {1'b0, v.root} + {1'b0, bitv};
		if ({1'b0, v.rem} >= tr) begin
			v.rem  = v.rem - RW'(tr);
			v.root = (v.root >> 1) + bitv;
		end else begin
			v.root = v.root >> 1;
		end
		return v;
	endfunction

	function automatic cord_t cord_init(logic signed [CW-1:0] y, logic signed [CW-1:0] x);
		cord_t c;
		c.zr = (x == '0) && (y == '0);
		c.x  = x;
		c.y  = y;
		c.a  = '0;
		if (x < 0) begin
			c.a = (y >= 0) ? PI_Q30 : -PI_Q30;
			c.x = -x;
			c.y = -y;
		end
		return c;
	endfunction

	function automatic cord_t cord_step(cord_t c, int i);
		logic signed [CW-1:0] xn;
		if (c.y > 0) begin
			xn  = c.x + (c.y >>> i);
			c.y = c.y - (c.x >>> i);
			c.a = c.a + atan_q30(i);
		end else begin
			xn  = c.x - (c.y >>> i);
			c.y = c.y + (c.x >>> i);
			c.a = c.a - atan_q30(i);
		end
		c.x = xn;
		return c;
	endfunction

	function automatic logic signed [QW-1:0] ang_q12(logic signed [49:0] hi,
		logic signed [49:0] lo);
		logic signed [67:0] p;
		p = (68'(hi) <<< 17) + 68'(lo) + (68'sd1 <<< 49);
		return QW'(p >>> 50) + HALF_Q12;
	endfunction

	function automatic logic signed [QW-1:0] pl_q12(logic signed [31:0] p);
		logic signed [31:0] r;
		r = (p + 32'sd16384) >>> 15;
		return QW'(r) + HALF_Q12;
	endfunction

	function automatic logic signed [QW-1:0] seam_fix(logic signed [QW-1:0] cur,
		logic signed [QW-1:0] prev);
		if (cur < SEAM_Q12 && prev > SEAM_Q12)
			return cur + ONE_Q12;
		else if (cur > SEAM_Q12 && prev < SEAM_Q12)
			return cur - ONE_Q12;
		return cur;
	endfunction

	function automatic logic signed [15:0] sat_out(logic signed [33:0] m);
		logic signed [33:0] r;
		r = (m + 34'sd2048) >>> 12;
		if (r > 34'sd32767)
			return 16'sd32767;
		if (r < -34'sd32768)
			return -16'sd32768;
		return 16'(r);
	endfunction

	// ---------------------------------------------------------------- pipeline
	logic en;
	logic vld_s9;
	assign en         = !vld_s9 || tc.ready;
	assign face.ready = en;

	// entry
	logic  vld_s1;
	item_t item_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (en)
			vld_s1 <= face.valid && (mode_q == MODE_PLANAR || mode_q == MODE_SPHERE);
	end
	always_ff @(posedge clk) begin
		if (en) begin
			item_s1.sph  <= (mode_q == MODE_SPHERE);
			item_s1.v[0] <= entry_f(face.v1_x, face.v1_y, face.v1_z, inv_x_q, inv_y_q);
			item_s1.v[1] <= entry_f(face.v2_x, face.v2_y, face.v2_z, inv_x_q, inv_y_q);
			item_s1.v[2] <= entry_f(face.v3_x, face.v3_y, face.v3_z, inv_x_q, inv_y_q);
		end
	end

	// square root for cos(asin(y)), one root bit per stage
	item_t sq_s2  [SQ_STEPS];
	logic  vld_sq_s2 [SQ_STEPS];
	for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sq
		item_t pv;
		logic  pvld;
		if (g == 0) begin : g_first
			assign pv   = item_s1;
			assign pvld = vld_s1;
		end else begin : g_next
			assign pv   = sq_s2[g-1];
			assign pvld = vld_sq_s2[g-1];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_sq_s2[g] <= 1'b0;
			else if (en)
				vld_sq_s2[g] <= pvld;
		end
		always_ff @(posedge clk) begin
			if (en) begin
				sq_s2[g].sph <= pv.sph;
				for (int k = 0; k < 3; k++)
					sq_s2[g].v[k] <= sq_vtx(pv.v[k], g);
			end
		end
	end

	// CORDIC setup: quadrant fold and zero detect
	item_t item_s3, nxt_s3;
	logic  vld_s3;
	always_comb begin
		nxt_s3 = sq_s2[SQ_STEPS-1];
		for (int k = 0; k < 3; k++) begin
			nxt_s3.v[k].cs = cord_init(CW'(sq_s2[SQ_STEPS-1].v[k].x) <<< 14,
				CW'(sq_s2[SQ_STEPS-1].v[k].z) <<< 14);
			nxt_s3.v[k].ct = cord_init(CW'(sq_s2[SQ_STEPS-1].v[k].yc) <<< 14,
				$signed(sq_s2[SQ_STEPS-1].v[k].root[CW-1:0]));
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s3 <= 1'b0;
		else if (en)
			vld_s3 <= vld_sq_s2[SQ_STEPS-1];
	end
	always_ff @(posedge clk) begin
		if (en)
			item_s3 <= nxt_s3;
	end

	// CORDIC vectoring, one iteration per stage
	item_t cor_s4 [NI];
	logic  vld_cor_s4 [NI];
	for (genvar i = 0; i < NI; i++) begin : g_cor
		item_t pv;
		item_t nx;
		logic  pvld;
		if (i == 0) begin : g_first
			assign pv   = item_s3;
			assign pvld = vld_s3;
		end else begin : g_next
			assign pv   = cor_s4[i-1];
			assign pvld = vld_cor_s4[i-1];
		end
		always_comb begin
			nx = pv;
			for (int k = 0; k < 3; k++) begin
				nx.v[k].cs = cord_step(pv.v[k].cs, i);
				nx.v[k].ct = cord_step(pv.v[k].ct, i);
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_cor_s4[i] <= 1'b0;
			else if (en)
				vld_cor_s4[i] <= pvld;
		end
		always_ff @(posedge clk) begin
			if (en)
				cor_s4[i] <= nx;
		end
	end

	// angle times 1/(2pi) or 1/pi, split into high and low partial products
	item_t item_s5, nxt_s5;
	logic  vld_s5;
	logic signed [AW-1:0] ang_s [3];
	logic signed [AW-1:0] ang_t [3];
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			ang_s[k] = cor_s4[NI-1].v[k].cs.zr ? '0 : cor_s4[NI-1].v[k].cs.a;
			ang_t[k] = cor_s4[NI-1].v[k].ct.zr ? '0 : cor_s4[NI-1].v[k].ct.a;
		end
	end
	always_comb begin
		nxt_s5 = cor_s4[NI-1];
		for (int k = 0; k < 3; k++) begin
			nxt_s5.v[k].shi = $signed(ang_s[k][AW-1:17]) * INV_2PI_Q32;
			nxt_s5.v[k].slo = $signed({1'b0, ang_s[k][16:0]}) * INV_2PI_Q32;
			nxt_s5.v[k].thi = $signed(ang_t[k][AW-1:17]) * INV_PI_Q32;
			nxt_s5.v[k].tlo = $signed({1'b0, ang_t[k][16:0]}) * INV_PI_Q32;
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s5 <= 1'b0;
		else if (en)
			vld_s5 <= vld_cor_s4[NI-1];
	end
	always_ff @(posedge clk) begin
		if (en)
			item_s5 <= nxt_s5;
	end

	// Q.12 coordinates, planar or sphere
	item_t item_s6, nxt_s6;
	logic  vld_s6;
	always_comb begin
		nxt_s6 = item_s5;
		for (int k = 0; k < 3; k++) begin
			nxt_s6.v[k].s = item_s5.sph ? ang_q12(item_s5.v[k].shi, item_s5.v[k].slo)
				: pl_q12(item_s5.v[k].ps);
			nxt_s6.v[k].t = item_s5.sph ? ang_q12(item_s5.v[k].thi, item_s5.v[k].tlo)
				: pl_q12(item_s5.v[k].pt);
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s6 <= 1'b0;
		else if (en)
			vld_s6 <= vld_s5;
	end
	always_ff @(posedge clk) begin
		if (en)
			item_s6 <= nxt_s6;
	end

	// seam: third s compares against the already adjusted second s
	item_t item_s7, nxt_s7;
	logic  vld_s7;
	logic signed [QW-1:0] s2_adj, s3_adj;
	always_comb begin
		s2_adj = seam_fix(item_s6.v[1].s, item_s6.v[0].s);
		s3_adj = seam_fix(item_s6.v[2].s, s2_adj);
		nxt_s7 = item_s6;
		if (item_s6.sph) begin
			nxt_s7.v[1].s = s2_adj;
			nxt_s7.v[2].s = s3_adj;
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s7 <= 1'b0;
		else if (en)
			vld_s7 <= vld_s6;
	end
	always_ff @(posedge clk) begin
		if (en)
			item_s7 <= nxt_s7;
	end

	// texture scale
	item_t item_s8, nxt_s8;
	logic  vld_s8;
	always_comb begin
		nxt_s8 = item_s7;
		for (int k = 0; k < 3; k++) begin
			nxt_s8.v[k].ms = item_s7.v[k].s * $signed({1'b0, scl_s_q});
			nxt_s8.v[k].mt = item_s7.v[k].t * $signed({1'b0, scl_t_q});
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s8 <= 1'b0;
		else if (en)
			vld_s8 <= vld_s7;
	end
	always_ff @(posedge clk) begin
		if (en)
			item_s8 <= nxt_s8;
	end

	// round, saturate, output register
	logic signed [15:0] s_out_s9 [3];
	logic signed [15:0] t_out_s9 [3];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s9 <= 1'b0;
		else if (en)
			vld_s9 <= vld_s8;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				s_out_s9[k] <= sat_out(item_s8.v[k].ms);
				t_out_s9[k] <= sat_out(item_s8.v[k].mt);
			end
		end
	end

	assign tc.valid    = vld_s9;
	assign tc.s_first  = s_out_s9[0];
	assign tc.t_first  = t_out_s9[0];
	assign tc.s_second = s_out_s9[1];
	assign tc.t_second = t_out_s9[1];
	assign tc.s_third  = s_out_s9[2];
	assign tc.t_third  = t_out_s9[2];

`ifndef SYNTHESIS
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(tc.valid && !tc.ready) |-> !face.ready)
		else $error("input accepted while output stalled");

	a_none_mode_drops: assert property (@(posedge clk) disable iff (!arst_n)
		(face.valid && face.ready && !(mode_q == MODE_PLANAR || mode_q == MODE_SPHERE))
		|=> !vld_s1)
		else $error("face in none mode entered the pipeline");
`endif

endmodule
